@@ design/mmgp_pkg.sv @@
`default_nettype none

package mmgp_pkg;

    // field widths
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned MODE_W     = 4;
    localparam int unsigned ARG_W      = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // internal widths
    localparam int unsigned SUM_W      = 10;
    localparam int unsigned PROD_W     = 21;
    localparam int unsigned LSUM_W     = 22;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned RECIP_W    = 17;

    // gray method codes
    localparam logic [MODE_W-1:0] MODE_AVG     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LUMA    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DESAT   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MIN     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MAX     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_RED     = 4'd6;
    localparam logic [MODE_W-1:0] MODE_GREEN   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_BLUE    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_LEVELS  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_BINARY  = 4'd11;
    localparam logic [MODE_W-1:0] MODE_INVERSE = 4'd12;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_ARG  = 2'd1;
    localparam logic [MODE_W-1:0]    GRAY_MODE_RST = MODE_AVG;
    localparam logic [ARG_W-1:0]     MODE_ARG_RST  = 9'd128;

    // level count limits
    localparam int unsigned LEVELS_MIN = 2;
    localparam int unsigned LEVELS_MAX = 256;
    localparam int unsigned PIX_MAX    = 255;

    // luminosity weights, sum 10000
    localparam logic [12:0] LUMA_W_RED   = 13'd2125;
    localparam logic [12:0] LUMA_W_GREEN = 13'd7154;
    localparam logic [12:0] LUMA_W_BLUE  = 13'd721;

    // divide by 3: (x * 683) >> 11, exact for x <= 765
    localparam int unsigned AVG_PROD_W = 20;
    localparam logic [SUM_W-1:0] AVG_RECIP = 10'd683;
    localparam int unsigned AVG_SHIFT  = 11;

    // divide by 10000: (x * ceil(2^36 / 10000)) >> 36, exact for x < 2^22
    localparam int unsigned LRECIP_W   = 23;
    localparam logic [LRECIP_W-1:0] LUMA_RECIP = 23'd6871948;
    localparam int unsigned LUMA_SHIFT = 36;
    localparam int unsigned LPROD_W    = LSUM_W + LRECIP_W;

    // level quantizer reciprocal scale
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned QPROD_W     = PIX_W + RECIP_W;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             last_out;
    } t_result;

    // after the statistics stages
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic              last;
        logic [PIX_W-1:0]  avg;
        logic [PIX_W-1:0]  mn;
        logic [PIX_W-1:0]  mx;
        logic [PIX_W-1:0]  desat;
        logic [LSUM_W-1:0] luma_sum;
    } t_pre;

    // after the scaling stages
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic              last;
        logic [PIX_W-1:0]  avg;
        logic [PIX_W-1:0]  mn;
        logic [PIX_W-1:0]  mx;
        logic [PIX_W-1:0]  desat;
        logic [PIX_W-1:0]  luma;
        logic [PIX_W-1:0]  rem;
        logic [STEP_W-1:0] step;
    } t_mid;

endpackage

`default_nettype wire

@@ design/multi_mode_grayscale_pixel.sv @@
// Converts one 8-bit RGB pixel per clock into one gray value. gray_mode (index 0,
// reset average) picks the method: average, luminosity (2125/7154/721 over 10000,
// floored), desaturation, minimum, maximum, red, green or blue alone, quantization
// of the average to N levels, binary threshold or inverse binary; other codes,
// the dither code included, give 255. mode_argument (index 1, reset 128) holds N
// (clamped to 2..256) or the threshold (strictly greater than it is white in
// binary, black in inverse). The last flag rides along with its pixel. Throughput
// is one pixel per clock while the output is not stalled; the result passes
// five register stages (the input transfer loads the first), of which the third
// carries the 22 x 23 bit luminosity reciprocal multiply. Configuration writes
// are always taken and act on pixels already in the pipe at the stages that read
// them; write them only while the pipe is empty.
`default_nettype none

module multi_mode_grayscale_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mmgp_pkg::t_pixel               i_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mmgp_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmgp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmgp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mmgp_pkg::*;

    logic [MODE_W-1:0] r_gray_mode;
    logic [ARG_W-1:0]  r_mode_arg;
    logic              w_pre_valid;
    t_pre              w_pre;
    logic              w_quot_ready;
    logic              w_mid_valid;
    t_mid              w_mid;
    logic              w_en5;
    logic              r_v5;
    t_result           r_res;
    t_result           n_res;
    logic [PIX_W-1:0]  w_rem;
    logic              w_above;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode <= GRAY_MODE_RST;
            r_mode_arg  <= MODE_ARG_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRAY_MODE: r_gray_mode <= i_cfg_data[MODE_W-1:0];
                REG_MODE_ARG:  r_mode_arg  <= i_cfg_data[ARG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stages 1 and 2
    mmgp_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_pix        (i_pixel),
        .o_ready      (o_in_ready),
        .o_valid      (w_pre_valid),
        .o_pre        (w_pre),
        .i_ready_next (w_quot_ready)
    );

    // stages 3 and 4
    mmgp_quot u_quot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode_arg   (r_mode_arg),
        .i_valid      (w_pre_valid),
        .i_pre        (w_pre),
        .o_ready      (w_quot_ready),
        .o_valid      (w_mid_valid),
        .o_mid        (w_mid),
        .i_ready_next (w_en5)
    );

    // stage 5: final remainder fix and method select
    assign w_en5   = !r_v5 || i_out_ready;
    assign w_rem   = (w_mid.rem >= w_mid.step) ? (w_mid.rem - w_mid.step) : w_mid.rem;
    assign w_above = ARG_W'(w_mid.avg) > r_mode_arg;

    always_comb begin
        n_res.last_out = w_mid.last;
        unique case (r_gray_mode)
            MODE_AVG:     n_res.gray = w_mid.avg;
            MODE_LUMA:    n_res.gray = w_mid.luma;
            MODE_DESAT:   n_res.gray = w_mid.desat;
            MODE_MIN:     n_res.gray = w_mid.mn;
            MODE_MAX:     n_res.gray = w_mid.mx;
            MODE_RED:     n_res.gray = w_mid.red;
            MODE_GREEN:   n_res.gray = w_mid.green;
            MODE_BLUE:    n_res.gray = w_mid.blue;
            MODE_LEVELS:  n_res.gray = w_mid.avg - w_rem;
            MODE_BINARY:  n_res.gray = w_above ? PIX_W'(PIX_MAX) : '0;
            MODE_INVERSE: n_res.gray = w_above ? '0 : PIX_W'(PIX_MAX);
            default:      n_res.gray = PIX_W'(PIX_MAX);
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en5) begin
            r_v5 <= w_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_v5;
    assign o_result    = r_res;

endmodule

`default_nettype wire

@@ design/mmgp_prep.sv @@
`default_nettype none

module mmgp_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mmgp_pkg::t_pixel i_pix,
    output logic            o_ready,
    output logic            o_valid,
    output mmgp_pkg::t_pre  o_pre,
    input  logic            i_ready_next
);
    import mmgp_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic              last;
        logic [SUM_W-1:0]  sum;
        logic [PIX_W-1:0]  mn;
        logic [PIX_W-1:0]  mx;
        logic [PROD_W-1:0] pr;
        logic [PROD_W-1:0] pg;
        logic [PROD_W-1:0] pb;
    } t_s1;

    logic      r_v1;
    logic      r_v2;
    t_s1       r_s1;
    t_s1       n_s1;
    t_pre      r_s2;
    t_pre      n_s2;
    logic      w_en1;
    logic      w_en2;
    logic [PIX_W-1:0]      w_mn_rg;
    logic [PIX_W-1:0]      w_mx_rg;
    logic [AVG_PROD_W-1:0] w_avg_prod;

    // stage advance: a stage moves when empty or when the next one moves
    assign w_en2   = !r_v2 || i_ready_next;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;
    assign o_pre   = r_s2;

    // stage 1: sum, min, max and weighted products
    always_comb begin
        w_mn_rg = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        w_mx_rg = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        n_s1.red   = i_pix.red;
        n_s1.green = i_pix.green;
        n_s1.blue  = i_pix.blue;
        n_s1.last  = i_pix.last_pixel;
        n_s1.sum   = SUM_W'(i_pix.red) + SUM_W'(i_pix.green) + SUM_W'(i_pix.blue);
        n_s1.mn    = (w_mn_rg < i_pix.blue) ? w_mn_rg : i_pix.blue;
        n_s1.mx    = (w_mx_rg > i_pix.blue) ? w_mx_rg : i_pix.blue;
        n_s1.pr    = PROD_W'(i_pix.red) * PROD_W'(LUMA_W_RED);
        n_s1.pg    = PROD_W'(i_pix.green) * PROD_W'(LUMA_W_GREEN);
        n_s1.pb    = PROD_W'(i_pix.blue) * PROD_W'(LUMA_W_BLUE);
    end

    // stage 2: average by reciprocal, luminosity sum, desaturation
    assign w_avg_prod = AVG_PROD_W'(r_s1.sum) * AVG_PROD_W'(AVG_RECIP);

    always_comb begin
        n_s2.red      = r_s1.red;
        n_s2.green    = r_s1.green;
        n_s2.blue     = r_s1.blue;
        n_s2.last     = r_s1.last;
        n_s2.avg      = w_avg_prod[AVG_SHIFT +: PIX_W];
        n_s2.mn       = r_s1.mn;
        n_s2.mx       = r_s1.mx;
        n_s2.desat    = PIX_W'(((PIX_W + 1)'(r_s1.mx) + (PIX_W + 1)'(r_s1.mn)) >> 1);
        n_s2.luma_sum = LSUM_W'(r_s1.pr) + LSUM_W'(r_s1.pg) + LSUM_W'(r_s1.pb);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

`default_nettype wire

@@ design/mmgp_quot.sv @@
`default_nettype none

module mmgp_quot (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mmgp_pkg::ARG_W-1:0] i_mode_arg,
    input  logic                      i_valid,
    input  mmgp_pkg::t_pre            i_pre,
    output logic                      o_ready,
    output logic                      o_valid,
    output mmgp_pkg::t_mid            o_mid,
    input  logic                      i_ready_next
);
    import mmgp_pkg::*;

    localparam int unsigned RomDepth = 1 << STEP_W;
    localparam int unsigned QsW      = 2 * PIX_W;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
        logic [PIX_W-1:0] avg;
        logic [PIX_W-1:0] mn;
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] desat;
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] q0;
    } t_s3;

    logic [STEP_W-1:0]  w_step_rom  [RomDepth];
    logic [RECIP_W-1:0] w_recip_rom [RomDepth];
    logic [STEP_W-1:0]  w_idx;
    logic [STEP_W-1:0]  r_step;
    logic [RECIP_W-1:0] r_recip;
    logic               r_v3;
    logic               r_v4;
    t_s3                r_s3;
    t_s3                n_s3;
    t_mid               r_s4;
    t_mid               n_s4;
    logic               w_en3;
    logic               w_en4;
    logic [LPROD_W-1:0] w_luma_prod;
    logic [QPROD_W-1:0] w_q_prod;
    logic [QsW-1:0]     w_qs;

    // step = floor(255 / (N-1)) and floor(2^16 / step), indexed by N-1
    for (genvar k = 0; k < RomDepth; k++) begin : g_rom
        localparam int unsigned Den    = (k == 0) ? 1 : k;
        localparam int unsigned StepK  = PIX_MAX / Den;
        localparam int unsigned RecipK = (1 << RECIP_SHIFT) / StepK;
        assign w_step_rom[k]  = STEP_W'(StepK);
        assign w_recip_rom[k] = RECIP_W'(RecipK);
    end

    // clamp the level count to 2..256
    always_comb begin
        if (i_mode_arg < ARG_W'(LEVELS_MIN)) begin
            w_idx = STEP_W'(LEVELS_MIN - 1);
        end else if (i_mode_arg > ARG_W'(LEVELS_MAX)) begin
            w_idx = STEP_W'(LEVELS_MAX - 1);
        end else begin
            w_idx = STEP_W'(i_mode_arg - ARG_W'(1));
        end
    end

    // quantizer constants follow the register
    always_ff @(posedge i_clk) begin
        r_step  <= w_step_rom[w_idx];
        r_recip <= w_recip_rom[w_idx];
    end

    assign w_en4   = !r_v4 || i_ready_next;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;
    assign o_valid = r_v4;
    assign o_mid   = r_s4;

    // stage 3: luminosity divide and quotient estimate by reciprocal
    assign w_luma_prod = LPROD_W'(i_pre.luma_sum) * LPROD_W'(LUMA_RECIP);
    assign w_q_prod    = QPROD_W'(i_pre.avg) * QPROD_W'(r_recip);

    always_comb begin
        n_s3.red   = i_pre.red;
        n_s3.green = i_pre.green;
        n_s3.blue  = i_pre.blue;
        n_s3.last  = i_pre.last;
        n_s3.avg   = i_pre.avg;
        n_s3.mn    = i_pre.mn;
        n_s3.mx    = i_pre.mx;
        n_s3.desat = i_pre.desat;
        n_s3.luma  = w_luma_prod[LUMA_SHIFT +: PIX_W];
        n_s3.q0    = w_q_prod[RECIP_SHIFT +: PIX_W];
    end

    // stage 4: remainder of the estimate, at most one step too large
    assign w_qs = QsW'(r_s3.q0) * QsW'(r_step);

    always_comb begin
        n_s4.red   = r_s3.red;
        n_s4.green = r_s3.green;
        n_s4.blue  = r_s3.blue;
        n_s4.last  = r_s3.last;
        n_s4.avg   = r_s3.avg;
        n_s4.mn    = r_s3.mn;
        n_s4.mx    = r_s3.mx;
        n_s4.desat = r_s3.desat;
        n_s4.luma  = r_s3.luma;
        n_s4.rem   = PIX_W'(QsW'(r_s3.avg) - w_qs);
        n_s4.step  = r_step;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3 <= n_s3;
        end
        if (w_en4) begin
            r_s4 <= n_s4;
        end
    end

endmodule

`default_nettype wire

@@ design/mmgp_check.sv @@
`default_nettype none

module mmgp_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input mmgp_pkg::t_result              o_result
);

    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an empty or draining output stage never blocks the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output can move");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped under stall");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_result))
        else $error("result changed under stall");

endmodule

bind multi_mode_grayscale_pixel mmgp_check u_check (.*);

`default_nettype wire

@@ sim/multi_mode_grayscale_pixel_tb.sv @@
`timescale 1ns / 1ps

module multi_mode_grayscale_pixel_tb;
    import mmgp_pkg::*;

    localparam int unsigned LATENCY    = 5;
    localparam int unsigned LUMA_DIV   = 10000;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int unsigned N_PHASES   = 20;
    localparam int unsigned PHASE_LEN  = 45;
    localparam int unsigned IDLE_PCT   = 36;
    localparam int unsigned BURST_PH   = 6;
    localparam int unsigned HOLD_PH    = 8;
    localparam int unsigned N_CODES    = 16;
    localparam int unsigned THRESH_HI  = 300;
    localparam int unsigned ARG_TOP    = 511;

    // indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // expected gray values, kept in transfer order
    class gray_tracker;
        logic [MODE_W-1:0] mode;
        logic [ARG_W-1:0]  arg;
        t_result           gray_due[$];
        int unsigned       errors;

        function new();
            mode   = GRAY_MODE_RST;
            arg    = MODE_ARG_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_GRAY_MODE) begin
                mode = data[MODE_W-1:0];
            end else if (idx == REG_MODE_ARG) begin
                arg = data[ARG_W-1:0];
            end
        endfunction

        function logic [PIX_W-1:0] calc_gray(t_pixel p);
            int unsigned r, g, b, avg, mn, mx, n, stp, val;
            r   = p.red;
            g   = p.green;
            b   = p.blue;
            avg = (r + g + b) / 3;
            mn  = (r < g) ? r : g;
            mn  = (mn < b) ? mn : b;
            mx  = (r > g) ? r : g;
            mx  = (mx > b) ? mx : b;
            case (mode)
                MODE_AVG:     val = avg;
                MODE_LUMA:    val = (LUMA_W_RED * r + LUMA_W_GREEN * g + LUMA_W_BLUE * b)
                                    / LUMA_DIV;
                MODE_DESAT:   val = (mx + mn) / 2;
                MODE_MIN:     val = mn;
                MODE_MAX:     val = mx;
                MODE_RED:     val = r;
                MODE_GREEN:   val = g;
                MODE_BLUE:    val = b;
                MODE_LEVELS: begin
                    n = arg;
                    if (n < LEVELS_MIN) n = LEVELS_MIN;
                    if (n > LEVELS_MAX) n = LEVELS_MAX;
                    stp = PIX_MAX / (n - 1);
                    val = (avg / stp) * stp;
                end
                MODE_BINARY:  val = (avg > arg) ? PIX_MAX : 0;
                MODE_INVERSE: val = (avg > arg) ? 0 : PIX_MAX;
                // dither and unknown codes
                default:      val = PIX_MAX;
            endcase
            return val[PIX_W-1:0];
        endfunction

        function void note_pixel(t_pixel p);
            t_result res;
            res.gray     = calc_gray(p);
            res.last_out = p.last_pixel;
            gray_due.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (gray_due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, expected none, actual gray %0d last %0d",
                         $time, got.gray, got.last_out);
                return;
            end
            want = gray_due.pop_front();
            if (got.gray !== want.gray) begin
                errors++;
                $display("%0t: gray mismatch, expected %0d, actual %0d (mode %0d arg %0d)",
                         $time, want.gray, got.gray, mode, arg);
            end
            if (got.last_out !== want.last_out) begin
                errors++;
                $display("%0t: last_out mismatch, expected %0d, actual %0d",
                         $time, want.last_out, got.last_out);
            end
        endfunction

        function int unsigned pending();
            return gray_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_pixel                i_pixel;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gray_tracker sb;
    bit          no_idle;
    int unsigned cycles;

    multi_mode_grayscale_pixel dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit roll_idle();
        return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic t_pixel mk_pixel(int unsigned r, int unsigned g, int unsigned b,
                                        int unsigned l);
        t_pixel p;
        p.red        = r[PIX_W-1:0];
        p.green      = g[PIX_W-1:0];
        p.blue       = b[PIX_W-1:0];
        p.last_pixel = l[0];
        return p;
    endfunction

    // channel value leaning toward the extremes now and then
    function automatic int unsigned rand_chan();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? PIX_MAX : 0;
        return $urandom_range(0, PIX_MAX);
    endfunction

    // receiver side stalls
    always @(negedge i_clk) begin
        i_out_ready <= !roll_idle();
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_result);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one pixel transfer, valid held until accepted
    task automatic send_pixel(t_pixel p);
        @(negedge i_clk);
        while (roll_idle()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_pixel(p);
    endtask

    // stop sending and wait for the pipe to empty
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(int unsigned mode_data, int unsigned arg);
        drain_pipe();
        write_reg(REG_GRAY_MODE, mode_data);
        write_reg(REG_MODE_ARG, arg);
    endtask

    initial begin
        int unsigned mode_data, arg, code;
        sb          = new();
        no_idle     = 1'b0;
        cycles      = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_pixel     = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: average with extreme pixels
        send_pixel(mk_pixel(0, 0, 0, 0));
        send_pixel(mk_pixel(PIX_MAX, PIX_MAX, PIX_MAX, 1));
        send_pixel(mk_pixel(PIX_MAX, 0, 1, 0));

        // every method code, dither and unknown ones too
        for (code = 0; code < N_CODES; code++) begin
            set_mode(code, MODE_ARG_RST);
            send_pixel(mk_pixel(code * 16 + 15, PIX_MAX - code * 13, code * 7, code % 2));
        end

        // level count clamping and thresholds above the pixel range
        set_mode(MODE_LEVELS, 0);
        send_pixel(mk_pixel(200, 100, 50, 0));
        set_mode(MODE_LEVELS, 1);
        send_pixel(mk_pixel(PIX_MAX, PIX_MAX, PIX_MAX, 1));
        set_mode(MODE_LEVELS, LEVELS_MAX);
        send_pixel(mk_pixel(201, 17, 99, 0));
        set_mode(MODE_LEVELS, ARG_TOP);
        send_pixel(mk_pixel(3, 250, 128, 1));
        set_mode(MODE_BINARY, THRESH_HI);
        send_pixel(mk_pixel(PIX_MAX, PIX_MAX, PIX_MAX, 0));
        set_mode(MODE_INVERSE, THRESH_HI);
        send_pixel(mk_pixel(PIX_MAX, PIX_MAX, PIX_MAX, 1));

        // random phases, each with its own setting
        for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin mode_data = MODE_LEVELS;  arg = 0;       end
                1: begin mode_data = MODE_LEVELS;  arg = ARG_TOP; end
                2: begin mode_data = MODE_BINARY;  arg = 0;       end
                3: begin mode_data = MODE_INVERSE; arg = ARG_TOP; end
                default: begin
                    mode_data = $urandom_range(0, ARG_TOP);
                    if (mode_data[MODE_W-1:0] == MODE_LEVELS && $urandom_range(0, 1))
                        arg = $urandom_range(0, 12);
                    else if ($urandom_range(0, 3) != 0)
                        arg = $urandom_range(0, PIX_MAX);
                    else
                        arg = $urandom_range(0, ARG_TOP);
                end
            endcase
            set_mode(mode_data, arg);
            // spare indexes must leave both registers alone
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          $urandom_range(0, ARG_TOP));
            no_idle = (ph == BURST_PH);
            for (int unsigned k = 0; k < PHASE_LEN; k++) begin
                // sender holds off until everything has come back
                if (ph == HOLD_PH && k == PHASE_LEN / 2) drain_pipe();
                send_pixel(mk_pixel(rand_chan(), rand_chan(), rand_chan(),
                                    $urandom_range(0, 7) == 0));
            end
            no_idle = 1'b0;
        end

        drain_pipe();
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
